// ===== hw/rtl/irdsd_pkg.sv =====
// irdsd_pkg: shared types, constants and tables of the ir distance display block
// no dependencies

package irdsd_pkg;

	localparam int QBITS       = 14;
	localparam int VAL_W       = 14;
	localparam int DISPLAY_MAX = 9999;
	localparam int SLOPE       = 2554;
	localparam int OFFSET      = 409000;
	localparam int SCALE       = 1000000000;
	// quotient exceeds the display range exactly when den <= SCALE / (DISPLAY_MAX + 1)
	localparam int SAT_DEN     = SCALE / (DISPLAY_MAX + 1);
	localparam int CFG_DATA_W  = 14;
	localparam int CFG_IDX_W   = 1;
	localparam int THR_W       = 12;
	localparam int FIFO_DEPTH  = 2;

	localparam logic [THR_W-1:0] THR_RESET  = 12'd250;
	localparam logic [VAL_W-1:0] OORV_RESET = 14'd9900;
	localparam logic [7:0]       DP_BIT     = 8'h80;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEAR_THRESHOLD   = 1'b0,
		CFG_OUT_OF_RANGE_VAL = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0] near_threshold;
		logic [VAL_W-1:0] out_of_range_value;
	} cfg_t;

	// one queue entry: the two values to show
	typedef struct packed {
		logic [VAL_W-1:0] distance;
		logic [VAL_W-1:0] shown;
	} entry_t;

	function automatic logic [6:0] digit_code(input logic [3:0] d);
		logic [6:0] c;
		unique case (d)
			4'd0: c = 7'h7E;
			4'd1: c = 7'h30;
			4'd2: c = 7'h6D;
			4'd3: c = 7'h79;
			4'd4: c = 7'h33;
			4'd5: c = 7'h5B;
			4'd6: c = 7'h5F;
			4'd7: c = 7'h70;
			4'd8: c = 7'h7F;
			4'd9: c = 7'h7B;
			default: c = 7'h7E;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/irdsd_ifs.sv =====
// irdsd_ifs: valid/ready channel interfaces for samples and display writes
// no dependencies

interface irdsd_in_if #(parameter int SAMPLE_BITS = 12) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface irdsd_out_if ();
	logic       valid;
	logic       ready;
	logic [3:0] digit_position;
	logic [7:0] segment_code;
	logic       last;

	modport source (output valid, output digit_position, output segment_code, output last,
		input ready);
	modport sink (input valid, input digit_position, input segment_code, input last,
		output ready);
endinterface

// ===== hw/rtl/irdsd_fifo.sv =====
// irdsd_fifo: small flop queue of display entries between front and back
// depends on irdsd_pkg

module irdsd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  irdsd_pkg::entry_t wdata,
	input  logic              pop,
	output irdsd_pkg::entry_t rdata,
	output logic              full,
	output logic              nempty
);
	import irdsd_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	entry_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]   cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign full   = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign nempty = (cnt_q != '0);
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nempty) else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
		else $error("queue count did not advance");

endmodule

// ===== hw/rtl/irdsd_front.sv =====
// irdsd_front: sample intake, range classification and pipelined reciprocal divider
// depends on irdsd_pkg, irdsd_ifs

module irdsd_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	irdsd_in_if.sink          smp,
	input  irdsd_pkg::cfg_t   cfg,
	input  logic              q_full,
	output logic              q_push,
	output irdsd_pkg::entry_t q_wdata
);
	import irdsd_pkg::*;

	localparam int NUM_W = SAMPLE_BITS + 12;
	localparam int DIV_W = NUM_W + QBITS;

	logic                 adv;

	logic                 v_s1;
	logic [NUM_W-1:0]     num_s1;
	logic                 low_s1;
	logic [VAL_W-1:0]     shown_s1;

	logic                 div_v_s     [QBITS+1];
	logic [DIV_W-1:0]     div_rem_s   [QBITS+1];
	logic [NUM_W-1:0]     div_den_s   [QBITS+1];
	logic [QBITS-1:0]     div_quo_s   [QBITS+1];
	logic                 div_oor_s   [QBITS+1];
	logic                 div_sat_s   [QBITS+1];
	logic [VAL_W-1:0]     div_shown_s [QBITS+1];

	logic [DIV_W-1:0]     trial  [QBITS+1];
	logic                 ge     [QBITS+1];
	logic [31:0]          s_ext;
	logic [VAL_W-1:0]     oorv_sat;
	logic [VAL_W-1:0]     distance;

	assign adv       = !div_v_s[QBITS] || !q_full;
	assign smp.ready = adv;
	assign q_push    = div_v_s[QBITS] && !q_full;
	assign s_ext     = 32'(smp.sample);

	// one quotient bit per stage, msb first
	always_comb begin
		trial[0] = '0;
		ge[0]    = 1'b0;
		for (int k = 1; k <= QBITS; k++) begin
			trial[k] = DIV_W'(div_den_s[k-1]) << (QBITS - k);
			ge[k]    = div_rem_s[k-1] >= trial[k];
		end
	end

	always_comb begin
		oorv_sat = (cfg.out_of_range_value > VAL_W'(DISPLAY_MAX)) ?
			VAL_W'(DISPLAY_MAX) : cfg.out_of_range_value;
		if (div_oor_s[QBITS]) begin
			distance = oorv_sat;
		end else if (div_sat_s[QBITS]) begin
			distance = VAL_W'(DISPLAY_MAX);
		end else begin
			distance = VAL_W'(div_quo_s[QBITS]);
		end
		q_wdata.distance = distance;
		q_wdata.shown    = div_shown_s[QBITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= QBITS; k++) begin
				div_v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1       <= smp.valid;
			div_v_s[0] <= v_s1;
			for (int k = 1; k <= QBITS; k++) begin
				div_v_s[k] <= div_v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1   <= NUM_W'(SLOPE) * NUM_W'(smp.sample);
			low_s1   <= s_ext < 32'(cfg.near_threshold);
			shown_s1 <= (s_ext > 32'(DISPLAY_MAX)) ? VAL_W'(DISPLAY_MAX) : VAL_W'(s_ext);

			div_rem_s[0]   <= DIV_W'(SCALE);
			div_den_s[0]   <= NUM_W'(num_s1 - NUM_W'(OFFSET));
			div_quo_s[0]   <= '0;
			div_oor_s[0]   <= low_s1 || (num_s1 <= NUM_W'(OFFSET));
			div_sat_s[0]   <= NUM_W'(num_s1 - NUM_W'(OFFSET)) <= NUM_W'(SAT_DEN);
			div_shown_s[0] <= shown_s1;

			for (int k = 1; k <= QBITS; k++) begin
				div_rem_s[k]   <= ge[k] ? DIV_W'(div_rem_s[k-1] - trial[k]) : div_rem_s[k-1];
				div_den_s[k]   <= div_den_s[k-1];
				div_quo_s[k]   <= {div_quo_s[k-1][QBITS-2:0], ge[k]};
				div_oor_s[k]   <= div_oor_s[k-1];
				div_sat_s[k]   <= div_sat_s[k-1];
				div_shown_s[k] <= div_shown_s[k-1];
			end
		end
	end

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid && smp.ready |=> v_s1) else $error("accepted beat lost at stage 1");
	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s[QBITS] && q_full |=> div_v_s[QBITS])
		else $error("divider output dropped while queue full");
	a_push_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_wdata.distance <= VAL_W'(DISPLAY_MAX)
		&& q_wdata.shown <= VAL_W'(DISPLAY_MAX))
		else $error("value out of display range");

endmodule

// ===== hw/rtl/irdsd_back.sv =====
// irdsd_back: digit extraction and seven-segment write sequencer, eight beats per entry
// depends on irdsd_pkg, irdsd_ifs

module irdsd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  irdsd_pkg::entry_t    head,
	input  logic                 head_valid,
	output logic                 pop,
	irdsd_out_if.source          res
);
	import irdsd_pkg::*;

	logic [2:0]       cnt_q;
	logic [VAL_W-1:0] work_q;
	logic             ovalid_q;
	logic [3:0]       pos_q;
	logic [7:0]       seg_q;
	logic             last_q;

	logic             load;
	logic [VAL_W-1:0] cur;
	logic [3:0]       dig;
	logic [VAL_W-1:0] rem;
	logic             dot;

	assign load = head_valid && (!ovalid_q || res.ready);
	assign pop  = load && (cnt_q == 3'd7);
	assign dot  = (cnt_q == 3'd1) || (cnt_q == 3'd4);

	assign res.valid          = ovalid_q;
	assign res.digit_position = pos_q;
	assign res.segment_code   = seg_q;
	assign res.last           = last_q;

	// leading decimal digit of a value below 10000, then shift the rest up one decade
	always_comb begin
		if (cnt_q == 3'd0) begin
			cur = head.distance;
		end else if (cnt_q == 3'd4) begin
			cur = head.shown;
		end else begin
			cur = work_q;
		end
		dig = '0;
		for (int k = 1; k <= 9; k++) begin
			if (cur >= VAL_W'(k * 1000)) begin
				dig = 4'(k);
			end
		end
		rem = VAL_W'(cur - VAL_W'(VAL_W'(dig) * VAL_W'(1000)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q    <= 3'(cnt_q + 1'b1);
				ovalid_q <= 1'b1;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			work_q <= VAL_W'(rem * VAL_W'(10));
			pos_q  <= 4'(4'd8 - 4'(cnt_q));
			seg_q  <= {1'b0, digit_code(dig)} | (dot ? DP_BIT : 8'h00);
			last_q <= (cnt_q == 3'd7);
		end
	end

	a_entry_held: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 3'd0 |-> head_valid) else $error("entry left mid-sequence");
	a_first_beat: assert property (@(posedge clk) disable iff (!arst_n)
		load && cnt_q == 3'd0 |=> res.valid && res.digit_position == 4'd8)
		else $error("sequence did not start at leftmost digit");
	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> res.valid && res.last && cnt_q == 3'd0)
		else $error("pop not aligned with last beat");
	a_dot_place: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.segment_code[7] ==
		(res.digit_position == 4'd7 || res.digit_position == 4'd4))
		else $error("decimal point misplaced");

endmodule

// ===== hw/rtl/ir_distance_to_segment_display.sv =====
// ir_distance_to_segment_display: top level, config registers, front, queue and back
// depends on irdsd_pkg, irdsd_ifs, irdsd_fifo, irdsd_front, irdsd_back
//
// channel  dir  payload                                 beats
// smp      in   sample[SAMPLE_BITS-1:0]                 one per sample
// res      out  digit_position[3:0] segment_code[7:0]   eight per sample, last on the eighth
//              last
// cfg      in   cfg_we, cfg_index[0], cfg_data[13:0]    one write per register
//
// sustained rate is set by the back sequencer, emitting one beat a cycle while res is ready
// first beat path: stage 1, the divider stages, the queue, then the back output register
// front takes a sample every cycle unless its last stage waits on a full two-entry queue
// res stalls hold the output register; front keeps filling the queue meanwhile
// arst_n clears all control state and loads register defaults 250 and 9900

module ir_distance_to_segment_display #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [irdsd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [irdsd_pkg::CFG_DATA_W-1:0]     cfg_data,
	irdsd_in_if.sink                             smp,
	irdsd_out_if.source                          res
);
	import irdsd_pkg::*;

	cfg_t      cfg_q;
	entry_t    q_wdata;
	entry_t    q_rdata;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_nempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_threshold     <= THR_RESET;
			cfg_q.out_of_range_value <= OORV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_NEAR_THRESHOLD:   cfg_q.near_threshold     <= cfg_data[THR_W-1:0];
				CFG_OUT_OF_RANGE_VAL: cfg_q.out_of_range_value <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	irdsd_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp     (smp),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	irdsd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.nempty (q_nempty)
	);

	irdsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rdata),
		.head_valid (q_nempty),
		.pop        (q_pop),
		.res        (res)
	);

endmodule
